// ----- hdl/lcle_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the literal code packer
// no dependencies
package lcle_pkg;

  localparam int LITERAL_WIDTH = 8;
  localparam int CODE_WIDTH    = LITERAL_WIDTH + 1;
  localparam int ACC_WIDTH     = 7 + 2 * CODE_WIDTH;

  localparam logic [CODE_WIDTH-1:0] CODE_CLEAR    = 9'd256;
  localparam logic [CODE_WIDTH-1:0] CODE_END      = 9'd257;
  localparam logic [CODE_WIDTH-1:0] CODE_FIRST    = 9'd258;
  localparam logic [CODE_WIDTH-1:0] CODE_LIMIT    = 9'd511;
  localparam logic [CODE_WIDTH-1:0] COUNTER_START = 9'd255;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [LITERAL_WIDTH-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
  } out_t;

  typedef struct packed {
    logic                     operation;
    logic                     clear;
    logic [LITERAL_WIDTH-1:0] data_byte;
  } cmd_t;

endpackage

// ----- hdl/lzw_compatible_literal_encoder.sv -----
`timescale 1ns / 1ps
// literal code packer top level; 9-bit codes packed msb-first into bytes
// first output byte path: queue entry, accumulator, output register
// throughput: one output byte per cycle from the packer while commands are
// queued and the output is not stalled, 1 to 3 bytes per input transaction;
// a two-entry queue lets the front end keep accepting while the packer drains
// reset: code counter to 255, no pending bits, queue and output register empty
module lzw_compatible_literal_encoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lcle_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output lcle_pkg::out_t out_item
);
  import lcle_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  lcle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  lcle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head_cmd)
  );

  lcle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_nonempty),
    .q_cmd   (head_cmd),
    .pop     (q_pop),
    .valid   (out_valid),
    .stall   (out_stall),
    .item    (out_item)
  );

endmodule

// ----- hdl/lcle_front.sv -----
`timescale 1ns / 1ps
// front end: accepts input transactions, tracks the code counter and
// decides where a clear code goes; depends on lcle_pkg
module lcle_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lcle_pkg::in_t in_item,
  input  logic         q_full,
  output logic         push,
  output lcle_pkg::cmd_t cmd
);
  import lcle_pkg::*;

  logic [CODE_WIDTH-1:0] code_counter;
  logic [CODE_WIDTH-1:0] code_counter_next;
  logic                  need_clear;

  assign in_stall   = q_full;
  assign push       = in_valid && !q_full;
  assign need_clear = (in_item.operation == OP_DATA) && (code_counter == CODE_LIMIT);

  assign cmd.operation = in_item.operation;
  assign cmd.clear     = need_clear;
  assign cmd.data_byte = in_item.data_byte;

  always_comb begin
    if (in_item.operation == OP_END) begin
      code_counter_next = COUNTER_START;
    end else if (need_clear) begin
      code_counter_next = CODE_FIRST + 9'd1;
    end else begin
      code_counter_next = code_counter + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_counter <= COUNTER_START;
    end else if (push) begin
      code_counter <= code_counter_next;
    end
  end

endmodule

// ----- hdl/lcle_queue.sv -----
`timescale 1ns / 1ps
// two-entry command queue between front end and packer
// depends on lcle_pkg
module lcle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcle_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output lcle_pkg::cmd_t head
);
  import lcle_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/lcle_back.sv -----
`timescale 1ns / 1ps
// packer: turns queued commands into msb-first code bits and emits one
// byte per cycle through an output register unless stalled; depends on lcle_pkg
module lcle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lcle_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           valid,
  input  logic           stall,
  output lcle_pkg::out_t item
);
  import lcle_pkg::*;

  logic                  busy;
  logic [ACC_WIDTH-1:0]  acc;
  logic [1:0]            bytes_left;
  logic [2:0]            pc;
  logic [6:0]            pend_l;
  logic                  item_end;

  logic                  emit;
  logic                  last_emit;
  logic                  two_codes;
  logic [6:0]            pend_src;
  logic [CODE_WIDTH-1:0] code_a;
  logic [ACC_WIDTH-1:0]  codes;
  logic [4:0]            nbits;
  logic [4:0]            total;
  logic [4:0]            total_up;
  logic [ACC_WIDTH-1:0]  load_acc;
  logic [1:0]            load_n;
  logic [2:0]            load_pc;

  assign emit      = busy && (!valid || !stall);
  assign last_emit = emit && (bytes_left == 2'd1);
  assign pop       = q_valid && (!busy || last_emit);

  // pending bits come straight from the accumulator when loading on the last byte
  assign pend_src  = busy ? acc[ACC_WIDTH-9 -: 7] : pend_l;
  assign two_codes = (q_cmd.operation == OP_DATA) && q_cmd.clear;

  always_comb begin
    if (q_cmd.operation == OP_END) begin
      code_a = CODE_END;
    end else if (q_cmd.clear) begin
      code_a = CODE_CLEAR;
    end else begin
      code_a = {1'b0, q_cmd.data_byte};
    end
    if (two_codes) begin
      codes = {CODE_CLEAR, 1'b0, q_cmd.data_byte, 7'b0};
      nbits = 5'd18;
    end else begin
      codes = {code_a, 16'b0};
      nbits = 5'd9;
    end
    total    = {2'b0, pc} + nbits;
    total_up = total + 5'd7;
    load_acc = {pend_src, 18'b0} | (codes >> pc);
    if (q_cmd.operation == OP_END) begin
      load_n  = total_up[4:3];
      load_pc = 3'd0;
    end else begin
      load_n  = total[4:3];
      load_pc = total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      valid  <= 1'b0;
      pc     <= 3'd0;
      pend_l <= 7'd0;
    end else begin
      if (emit) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        pc   <= load_pc;
      end else if (last_emit) begin
        busy <= 1'b0;
      end
      if (last_emit) begin
        pend_l <= acc[ACC_WIDTH-9 -: 7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item.out_byte      <= acc[ACC_WIDTH-1 -: 8];
      item.last_of_run   <= last_emit;
      item.end_of_stream <= last_emit && item_end;
    end
    if (pop) begin
      acc        <= load_acc;
      bytes_left <= load_n;
      item_end   <= (q_cmd.operation == OP_END);
    end else if (emit) begin
      acc        <= acc << 8;
      bytes_left <= bytes_left - 2'd1;
    end
  end

endmodule

// ----- verif/lzw_compatible_literal_encoder_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the literal code packer: directed and random byte streams,
// a bit-exact packing predictor in a scoreboard class, random output stalls and random input gaps
// depends on hdl/lcle_pkg.sv and hdl/lzw_compatible_literal_encoder.sv
module lzw_compatible_literal_encoder_tb;
  import lcle_pkg::*;

  class packer_scoreboard;
    logic [6:0] pend_bits;
    logic [2:0] pend_cnt;
    logic [CODE_WIDTH-1:0] code_ctr;
    out_t byte_q[$];
    int errors;
    int checked;
    int clears;
    int streams;

    function new();
      errors = 0;
      checked = 0;
      clears = 0;
      streams = 0;
      restart();
    endfunction

    function void restart();
      pend_bits = '0;
      pend_cnt = '0;
      code_ctr = COUNTER_START;
    endfunction

    // append one 9-bit code, queue every completed byte
    function void pack_code(logic [CODE_WIDTH-1:0] code);
      logic [15:0] acc;
      int cnt;
      out_t r;
      acc = {pend_bits, code};
      cnt = pend_cnt + CODE_WIDTH;
      while (cnt >= 8) begin
        r.out_byte = 8'(acc >> (cnt - 8));
        r.last_of_run = 1'b0;
        r.end_of_stream = 1'b0;
        byte_q.push_back(r);
        cnt -= 8;
      end
      pend_cnt = 3'(cnt);
      pend_bits = 7'(acc & ((16'd1 << cnt) - 16'd1));
    endfunction

    function void note_input(in_t it);
      out_t pad;
      logic [7:0] tail;
      if (it.operation == OP_DATA) begin
        if (code_ctr == CODE_LIMIT) begin
          pack_code(CODE_CLEAR);
          code_ctr = CODE_FIRST;
          clears++;
        end
        pack_code({1'b0, it.data_byte});
        code_ctr = code_ctr + 1'b1;
        byte_q[byte_q.size() - 1].last_of_run = 1'b1;
      end else begin
        pack_code(CODE_END);
        if (pend_cnt != 0) begin
          tail = {1'b0, pend_bits};
          pad.out_byte = tail << (8 - pend_cnt);
          pad.last_of_run = 1'b0;
          pad.end_of_stream = 1'b0;
          byte_q.push_back(pad);
        end
        byte_q[byte_q.size() - 1].last_of_run = 1'b1;
        byte_q[byte_q.size() - 1].end_of_stream = 1'b1;
        restart();
        streams++;
      end
    endfunction

    task report(string what, int got, int want);
      if (errors < 30)
        $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (byte_q.size() == 0) begin
        report("output transaction with nothing expected, byte", got.out_byte, 0);
      end else begin
        want = byte_q.pop_front();
        checked++;
        if (got.out_byte !== want.out_byte)
          report("out_byte", got.out_byte, want.out_byte);
        if (got.last_of_run !== want.last_of_run)
          report("last_of_run", got.last_of_run, want.last_of_run);
        if (got.end_of_stream !== want.end_of_stream)
          report("end_of_stream", got.end_of_stream, want.end_of_stream);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  packer_scoreboard sb = new();
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int sent = 0;

  lzw_compatible_literal_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  // inputs are noted before outputs are checked within one edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(in_item);
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 250;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] data);
    in_t it;
    it.operation = op;
    it.data_byte = data;
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++) send_item(OP_DATA, 8'($urandom_range(255)));
    send_item(OP_END, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.byte_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("timeout with %0d output transactions outstanding", sb.byte_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // seven literals then end: end code lands on a byte boundary, no padding
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'hAA);
    send_item(OP_DATA, 8'h55);
    send_item(OP_DATA, 8'h7F);
    send_item(OP_END, 8'hFF);
    // empty stream, data field ignored
    send_item(OP_END, 8'h00);
    send_item(OP_DATA, 8'hFE);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h33);
    send_item(OP_END, 8'h5A);
    drain();

    // long stream: one clear insertion after the table fills
    for (int i = 0; i < 300; i++) begin
      if (i == 10) hold_req = 1'b1;
      calm = (i >= 150 && i < 260);
      send_item(OP_DATA, 8'($urandom_range(255)));
    end
    calm = 1'b0;
    send_item(OP_END, 8'($urandom_range(255)));
    drain();

    while (sent < 450) begin
      send_stream($urandom_range(20, 0));
      if ($urandom_range(4) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d input transactions in %0d streams with %0d clear codes inserted",
             sent, sb.streams, sb.clears);
    $display("checked %0d output transactions, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.byte_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
